/* design/cds_pkg.sv */
// Shared types, codes and helper functions for the calendar date stepper.
// No dependencies; every other design file refers to it by scoped names.
package cds_pkg;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [15:0] DIV25_RECIP = 16'd41944;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_LOAD = 2'd2,
    OP_CMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_LIMIT   = 2'd2
  } status_t;

  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;
  localparam logic signed [1:0] ORD_LT = -2'sd1;

  typedef struct packed {
    op_t         op;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
  } item_t;

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               leap;
    status_t            status;
    logic signed [1:0]  order;
  } result_t;

  // y % 25 by reciprocal multiply, exact for all 14-bit values
  function automatic logic is_leap(input logic [13:0] y);
    logic [29:0] prod;
    logic [9:0]  quo;
    logic [13:0] rem;
    prod = 30'(y) * 30'(DIV25_RECIP);
    quo  = prod[29:20];
    rem  = y - (14'({quo, 4'b0000}) + 14'({quo, 3'b000}) + 14'(quo));
    return (y[1:0] == 2'b00) && ((rem != 14'd0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* design/cds_input_reg.sv */
// Input register of the date stepper: holds one accepted command.
// Depends on cds_pkg for the item type.
module cds_input_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cds_pkg::item_t in_item,
  output logic           held_valid,
  output cds_pkg::item_t held_item,
  input  logic           take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

/* design/cds_date_unit.sv */
// Stored date and the single-pass step, load and compare logic.
// Depends on cds_pkg for types, codes, leap rule and month lengths.
module cds_date_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  cds_pkg::item_t   item,
  output cds_pkg::result_t result
);

  logic [13:0]       year, year_next;
  logic [3:0]        month, month_next;
  logic [4:0]        day, day_next;
  logic              leap;
  logic              load_leap;
  logic [4:0]        cur_len;
  logic [4:0]        prev_len;
  logic [4:0]        load_len;
  logic [3:0]        month_prev;
  cds_pkg::status_t  status;
  logic signed [1:0] order;

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= 14'd0;
      month <= 4'd1;
      day   <= 5'd1;
      leap  <= 1'b1;
    end else if (fire) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      leap  <= result.leap;
    end
  end

  assign load_leap  = cds_pkg::is_leap(item.load_year);
  assign cur_len    = cds_pkg::month_len(leap, month);
  assign month_prev = 4'(month - 4'd1);
  assign prev_len   = cds_pkg::month_len(leap, month_prev);
  assign load_len   = cds_pkg::month_len(load_leap, item.load_month);

  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    status     = cds_pkg::STAT_OK;
    order      = cds_pkg::ORD_EQ;
    case (item.op)
      cds_pkg::OP_INC: begin
        if (year == cds_pkg::YEAR_MAX && month == 4'd12 && day == 5'd31) begin
          status = cds_pkg::STAT_LIMIT;
        end else if (day >= cur_len) begin
          day_next = 5'd1;
          if (month >= 4'd12) begin
            month_next = 4'd1;
            year_next  = 14'(year + 14'd1);
          end else begin
            month_next = 4'(month + 4'd1);
          end
        end else begin
          day_next = 5'(day + 5'd1);
        end
      end
      cds_pkg::OP_DEC: begin
        if (year == 14'd0 && month == 4'd1 && day == 5'd1) begin
          status = cds_pkg::STAT_LIMIT;
        end else if (day <= 5'd1) begin
          if (month <= 4'd1) begin
            month_next = 4'd12;
            year_next  = 14'(year - 14'd1);
            day_next   = 5'd31;
          end else begin
            month_next = month_prev;
            day_next   = prev_len;
          end
        end else begin
          day_next = 5'(day - 5'd1);
        end
      end
      cds_pkg::OP_LOAD: begin
        if (item.load_year <= cds_pkg::YEAR_MAX && item.load_month inside {[4'd1:4'd12]} &&
            item.load_day >= 5'd1 && item.load_day <= load_len) begin
          year_next  = item.load_year;
          month_next = item.load_month;
          day_next   = item.load_day;
        end else begin
          status = cds_pkg::STAT_INVALID;
        end
      end
      cds_pkg::OP_CMP: begin
        if (year != item.load_year) begin
          order = (year > item.load_year) ? cds_pkg::ORD_GT : cds_pkg::ORD_LT;
        end else if (month != item.load_month) begin
          order = (month > item.load_month) ? cds_pkg::ORD_GT : cds_pkg::ORD_LT;
        end else if (day != item.load_day) begin
          order = (day > item.load_day) ? cds_pkg::ORD_GT : cds_pkg::ORD_LT;
        end
      end
      default: begin
        status = cds_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    result.year   = year_next;
    result.month  = month_next;
    result.day    = day_next;
    result.leap   = (year_next == year) ? leap : cds_pkg::is_leap(year_next);
    result.status = status;
    result.order  = order;
  end

endmodule

/* design/cds_output_reg.sv */
// Result register of the date stepper: holds one finished result for the sink.
// Depends on cds_pkg for the result type.
module cds_output_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cds_pkg::result_t load_result,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output cds_pkg::result_t out_result
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

/* design/calendar_date_stepper.sv */
// Top level of the calendar date stepper: stream ports, input and result registers.
// Depends on cds_pkg, cds_input_reg, cds_date_unit and cds_output_reg.
//
//   channel   direction  content
//   s_*       in         command: tuser = op, tdata = date to load or compare
//   m_*       out        stored date, leap flag, status and compare order
//
// One command per cycle sustained while the sink accepts; a held command is stepped and
// loaded into the result register once that register has space. The stored date register
// is the only loop. Reset sets the date to 0000-01-01 and empties both registers.
// A stalled sink holds the result register and then the input register.
module calendar_date_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // load_year[13:0], load_month[17:14], load_day[22:18], zero
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // year, month, day, leap, status, order, zero fill
);

  cds_pkg::item_t   in_item;
  cds_pkg::item_t   held_item;
  cds_pkg::result_t step_result;
  cds_pkg::result_t out_result;
  logic             held_valid;
  logic             space;
  logic             advance;

  always_comb begin
    in_item.op         = cds_pkg::op_t'(s_tuser);
    in_item.load_year  = s_tdata[13:0];
    in_item.load_month = s_tdata[17:14];
    in_item.load_day   = s_tdata[22:18];
  end

  assign advance = held_valid && space;

  cds_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (advance)
  );

  cds_date_unit u_date_unit (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (held_item),
    .result (step_result)
  );

  cds_output_reg u_output_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_result (step_result),
    .space       (space),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  assign m_tdata = {4'b0000, out_result.order, out_result.status, out_result.leap,
                    out_result.day, out_result.month, out_result.year};

endmodule

/* tb/sv/tb_calendar_date_stepper.sv */
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_stepper: directed limit, leap-year and
// invalid-load cases, then random load/step/compare runs under several flow-control phases.
// Depends on cds_pkg and the calendar_date_stepper RTL only.
module tb_calendar_date_stepper;

  class date_scoreboard;
    int unsigned      cur_year;
    int unsigned      cur_month;
    int unsigned      cur_day;
    cds_pkg::result_t pending_dates[$];
    int unsigned      n_errors;
    int unsigned      n_checked;
    int unsigned      op_count[4];
    int unsigned      limit_hits;
    int unsigned      rejected_loads;

    function new();
      cur_year  = 0;
      cur_month = 1;
      cur_day   = 1;
    endfunction

    function bit leap_of(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      if (m < 1 || m > 12) return 0;
      if (m == 2) return leap_of(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    function logic signed [1:0] sign_of(int unsigned a, int unsigned b);
      if (a > b) return cds_pkg::ORD_GT;
      if (a < b) return cds_pkg::ORD_LT;
      return cds_pkg::ORD_EQ;
    endfunction

    function void note_command(cds_pkg::op_t op, int unsigned ly, int unsigned lm,
                               int unsigned ld);
      cds_pkg::result_t r;
      r.status = cds_pkg::STAT_OK;
      r.order  = cds_pkg::ORD_EQ;
      op_count[op]++;
      case (op)
        cds_pkg::OP_INC: begin
          if (cur_year == cds_pkg::YEAR_MAX && cur_month == 12 && cur_day == 31) begin
            r.status = cds_pkg::STAT_LIMIT;
          end else if (cur_day >= month_days(cur_year, cur_month)) begin
            cur_day = 1;
            if (cur_month == 12) begin
              cur_month = 1;
              cur_year++;
            end else begin
              cur_month++;
            end
          end else begin
            cur_day++;
          end
        end
        cds_pkg::OP_DEC: begin
          if (cur_year == 0 && cur_month == 1 && cur_day == 1) begin
            r.status = cds_pkg::STAT_LIMIT;
          end else if (cur_day == 1) begin
            if (cur_month == 1) begin
              cur_month = 12;
              cur_year--;
            end else begin
              cur_month--;
            end
            cur_day = month_days(cur_year, cur_month);
          end else begin
            cur_day--;
          end
        end
        cds_pkg::OP_LOAD: begin
          if (ly <= cds_pkg::YEAR_MAX && lm >= 1 && lm <= 12 && ld >= 1 &&
              ld <= month_days(ly, lm)) begin
            cur_year  = ly;
            cur_month = lm;
            cur_day   = ld;
          end else begin
            r.status = cds_pkg::STAT_INVALID;
          end
        end
        default: begin
          r.order = sign_of(cur_year, ly);
          if (r.order == cds_pkg::ORD_EQ) r.order = sign_of(cur_month, lm);
          if (r.order == cds_pkg::ORD_EQ) r.order = sign_of(cur_day, ld);
        end
      endcase
      if (r.status == cds_pkg::STAT_LIMIT) limit_hits++;
      if (r.status == cds_pkg::STAT_INVALID) rejected_loads++;
      r.year  = 14'(cur_year);
      r.month = 4'(cur_month);
      r.day   = 5'(cur_day);
      r.leap  = leap_of(cur_year);
      pending_dates.push_back(r);
    endfunction

    function void report(string field, int exp_v, int act_v);
      $display("%0t: mismatch in %s: expected %0d, got %0d", $time, field, exp_v, act_v);
      n_errors++;
    endfunction

    function void check_result(logic [31:0] data);
      cds_pkg::result_t e;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, got %h", $time, data);
        n_errors++;
        return;
      end
      e = pending_dates.pop_front();
      n_checked++;
      if (data[13:0] != e.year) report("year", e.year, data[13:0]);
      if (data[17:14] != e.month) report("month", e.month, data[17:14]);
      if (data[22:18] != e.day) report("day", e.day, data[22:18]);
      if (data[23] != e.leap) report("leap", e.leap, data[23]);
      if (data[25:24] != e.status) report("status", e.status, data[25:24]);
      if (data[27:26] != 2'(e.order)) report("order", e.order, $signed(data[27:26]));
      if (data[31:28] != 4'd0) report("fill", 0, data[31:28]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = cds_pkg::OP_INC;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  date_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  int unsigned hot_years[13] = '{0, 1, 3, 4, 100, 400, 1600, 1900, 2000, 2100, 9996,
                                 9998, 9999};

  calendar_date_stepper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 64;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == 2000) begin
      $display("%0t: no transfer for 2000 cycles", $time);
      $display("tb_calendar_date_stepper NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(cds_pkg::op_t op, int unsigned y, int unsigned m, int unsigned d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, 5'(d), 4'(m), 14'(y)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(op, 14'(y), 4'(m), 5'(d));
    items_sent++;
  endtask

  // load a date, often near a boundary and sometimes broken, then step and compare from it
  task automatic run_sequence();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned steps;
    int unsigned r;
    bit          fwd;
    y = $urandom_range(1) ? hot_years[$urandom_range(12)] : $urandom_range(9999);
    case ($urandom_range(3))
      0: m = 1;
      1: m = 2;
      2: m = 12;
      default: m = $urandom_range(1, 12);
    endcase
    case ($urandom_range(2))
      0: d = 1;
      1: d = sb.month_days(y, m);
      default: d = $urandom_range(1, sb.month_days(y, m));
    endcase
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: d = sb.month_days(y, m) + 1;
        1: m = $urandom_range(1) ? 0 : $urandom_range(13, 15);
        default: y = $urandom_range(10000, 16383);
      endcase
    end
    send_cmd(cds_pkg::OP_LOAD, y, m, d);
    fwd = $urandom_range(1);
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 12) begin
        y = sb.cur_year;
        m = sb.cur_month;
        d = sb.cur_day;
        case ($urandom_range(3))
          0: y = y + $urandom_range(2) - 1;
          1: m = m + $urandom_range(2) - 1;
          2: d = d + $urandom_range(2) - 1;
          default: ;
        endcase
        send_cmd(cds_pkg::OP_CMP, y, m, d);
      end else begin
        send_cmd(((r < 27) ^ fwd) ? cds_pkg::OP_INC : cds_pkg::OP_DEC,
                 $urandom_range(16383), $urandom_range(15), $urandom_range(31));
      end
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
    int unsigned target;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 12) begin
        send_cmd(cds_pkg::op_t'($urandom_range(3)), $urandom_range(16383),
                 $urandom_range(15), $urandom_range(31));
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(cds_pkg::OP_DEC, 0, 0, 0);
    send_cmd(cds_pkg::OP_CMP, 0, 1, 1);
    send_cmd(cds_pkg::OP_INC, 0, 0, 0);
    send_cmd(cds_pkg::OP_DEC, 16383, 15, 31);
    send_cmd(cds_pkg::OP_LOAD, 9999, 12, 31);
    send_cmd(cds_pkg::OP_INC, 0, 0, 0);
    send_cmd(cds_pkg::OP_CMP, 16383, 15, 31);
    send_cmd(cds_pkg::OP_LOAD, 10000, 1, 1);
    send_cmd(cds_pkg::OP_LOAD, 16383, 15, 31);
    send_cmd(cds_pkg::OP_LOAD, 2000, 0, 1);
    send_cmd(cds_pkg::OP_LOAD, 2000, 13, 1);
    send_cmd(cds_pkg::OP_LOAD, 2000, 4, 31);
    send_cmd(cds_pkg::OP_LOAD, 1900, 2, 29);
    send_cmd(cds_pkg::OP_LOAD, 2000, 1, 0);
    send_cmd(cds_pkg::OP_LOAD, 2000, 2, 29);
    send_cmd(cds_pkg::OP_INC, 0, 0, 0);
    send_cmd(cds_pkg::OP_DEC, 0, 0, 0);
    send_cmd(cds_pkg::OP_LOAD, 1900, 3, 1);
    send_cmd(cds_pkg::OP_DEC, 0, 0, 0);
    send_cmd(cds_pkg::OP_LOAD, 1999, 12, 31);
    send_cmd(cds_pkg::OP_INC, 0, 0, 0);
    send_cmd(cds_pkg::OP_DEC, 0, 0, 0);
    send_cmd(cds_pkg::OP_CMP, 1999, 12, 30);
    send_cmd(cds_pkg::OP_CMP, 0, 0, 0);
    send_cmd(cds_pkg::OP_LOAD, 2024, 2, 29);

    run_phase(0, 0, 190);
    run_phase(74, 0, 170);
    run_phase(0, 74, 170);
    run_phase(6, 6, 170);
    hold_requests++;
    run_phase(0, 0, 120);
    hold_requests++;
    run_phase(0, 30, 120);

    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d results checked: %0d steps forward, %0d back, %0d loads (%0d rejected),",
             sb.n_checked, sb.op_count[cds_pkg::OP_INC], sb.op_count[cds_pkg::OP_DEC],
             sb.op_count[cds_pkg::OP_LOAD], sb.rejected_loads);
    $display("%0d compares, %0d steps refused at the date limits, %0d mismatches",
             sb.op_count[cds_pkg::OP_CMP], sb.limit_hits, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_calendar_date_stepper OK");
    end else begin
      $display("tb_calendar_date_stepper NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
design/cds_pkg.sv
design/cds_input_reg.sv
design/cds_date_unit.sv
design/cds_output_reg.sv
design/calendar_date_stepper.sv
tb/sv/tb_calendar_date_stepper.sv
